FILE: hw/rtl/ltstdp_pkg.sv
// shared types and constants for the lookup-table stdp weight update block
`default_nettype none

package ltstdp_pkg;

  localparam int WEIGHT_W = 16;
  localparam int AGE_W    = 8;
  localparam int AMPR_W   = 20;
  localparam int TAU_W    = 7;
  localparam int REM_W    = TAU_W - 1;
  localparam int SHIFT_W  = 5;
  localparam int LIMIT_W  = 15;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 3;

  // quotient bits resolved per divider cycle
  localparam int DIV_STEP = 4;

  localparam logic [AGE_W-1:0] AGE_MAX = 8'hFF;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_LTP_AMP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LTD_AMP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LTP_TAU   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LTD_TAU   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LTP_SHIFT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LTD_SHIFT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCIT     = 3'd7;

  typedef struct packed {
    logic                       command;
    logic                       pre_spike;
    logic                       post_spike;
    logic signed [WEIGHT_W-1:0] load_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight_out;
    logic                       updated;
  } out_beat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ltstdp_div.sv
// iterative divider: wide unsigned dividend by a small divisor, several bits a cycle
`default_nettype none

module ltstdp_div #(
  parameter int AMP_BITS = 20
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [AMP_BITS-1:0]            dividend,
  input  wire logic [ltstdp_pkg::TAU_W-1:0]   divisor,
  output logic                                done,
  output logic [AMP_BITS-1:0]                 quotient
);

  localparam int NCYC  = (AMP_BITS + ltstdp_pkg::DIV_STEP - 1) / ltstdp_pkg::DIV_STEP;
  localparam int NPAD  = NCYC * ltstdp_pkg::DIV_STEP;
  localparam int CNT_W = $clog2(NCYC + 1);

  logic [NPAD-1:0]                  num_r;
  logic [NPAD-1:0]                  quo_r;
  logic [ltstdp_pkg::REM_W-1:0]     rem_r;
  logic [ltstdp_pkg::TAU_W-1:0]     div_r;
  logic [CNT_W-1:0]                 cnt_r;
  logic                             busy_r;
  logic                             done_r;

  logic [NPAD-1:0]                  num_nxt;
  logic [NPAD-1:0]                  quo_nxt;
  logic [ltstdp_pkg::REM_W-1:0]     rem_nxt;
  logic [ltstdp_pkg::TAU_W-1:0]     trial;

  // restoring long division, DIV_STEP dividend bits per cycle
  always_comb begin
    num_nxt = num_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    trial   = '0;
    for (int k = 0; k < ltstdp_pkg::DIV_STEP; k++) begin
      trial   = {rem_nxt, num_nxt[NPAD-1]};
      num_nxt = {num_nxt[NPAD-2:0], 1'b0};
      if (trial >= div_r) begin
        rem_nxt = ltstdp_pkg::REM_W'(trial - div_r);
        quo_nxt = {quo_nxt[NPAD-2:0], 1'b1};
      end else begin
        rem_nxt = trial[ltstdp_pkg::REM_W-1:0];
        quo_nxt = {quo_nxt[NPAD-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r  <= NPAD'(dividend);
        quo_r  <= '0;
        rem_r  <= '0;
        div_r  <= divisor;
        cnt_r  <= CNT_W'(NCYC - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        num_r <= num_nxt;
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[AMP_BITS-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/lookup_table_stdp_weight_update_top.sv
// pair-based stdp synapse: spike ages, table-driven weight update and clamp
//
//  channel | direction | handshake           | beat
//  in_     | input     | in_valid / in_stall | ltstdp_pkg::in_beat_t
//  out_    | output    | out_valid/out_stall | ltstdp_pkg::out_beat_t
//  cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// a load or a quiet tick goes from accept to the done state, then into the result register
// a spiking tick walks the table recurrence in the shared divider: per table a setup
// state, idx divider steps (idx the age, if below 3*tau) and an add state, then the clamp state
// one beat in flight: in_stall is high from accept until its result is registered
// the result register holds while out_stall is high; synchronous reset, no clearing pass
`default_nettype none

module lookup_table_stdp_weight_update_top #(
  parameter int MAX_TAU  = 64,
  parameter int AMP_BITS = 20
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire ltstdp_pkg::in_beat_t                 in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output ltstdp_pkg::out_beat_t                     out_data,
  input  wire logic                                 cfg_we,
  input  wire logic [ltstdp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ltstdp_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int ACC_W = ((AMP_BITS > ltstdp_pkg::WEIGHT_W) ? AMP_BITS
                                                            : ltstdp_pkg::WEIGHT_W) + 2;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SETUP = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_ADD   = 7'b0001000,
    S_CLAMP = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_t;

  state_t state_r;

  // configuration
  logic [ltstdp_pkg::AMPR_W-1:0]    ltp_amp_r, ltd_amp_r;
  logic [ltstdp_pkg::TAU_W-1:0]     ltp_tau_r, ltd_tau_r;
  logic [ltstdp_pkg::SHIFT_W-1:0]   ltp_shift_r, ltd_shift_r;
  logic [ltstdp_pkg::LIMIT_W-1:0]   limit_r;
  logic                             excit_r;

  // synapse state
  logic signed [ltstdp_pkg::WEIGHT_W-1:0] weight_r;
  logic [ltstdp_pkg::AGE_W-1:0]     pre_age_r, post_age_r;

  // working registers
  logic                             pre_r;
  logic                             phase_ltd_r;
  logic                             upd_r;
  logic signed [ACC_W-1:0]          acc_r;
  logic [AMP_BITS-1:0]              mag_r;
  logic [ltstdp_pkg::AGE_W-1:0]     idx_r, iter_r;
  logic [ltstdp_pkg::TAU_W-1:0]     tau_r;
  logic                             div_start_r;
  logic                             div_start_nxt;
  logic                             out_valid_r;
  ltstdp_pkg::out_beat_t            out_data_r;

  logic                             div_done;
  logic [AMP_BITS-1:0]              div_quo;

  // table selection for the current phase
  logic [ltstdp_pkg::TAU_W-1:0]     sel_tau;
  logic [ltstdp_pkg::TAU_W-1:0]     sel_tau_eff;
  logic [ltstdp_pkg::AGE_W:0]       sel_len;
  logic [ltstdp_pkg::AGE_W-1:0]     sel_idx;
  logic [AMP_BITS-1:0]              sel_amp;
  logic                             sel_zero;

  logic [ltstdp_pkg::SHIFT_W-1:0]   sel_shift;
  logic [AMP_BITS-1:0]              term;
  logic                             term_rnd;
  logic signed [ACC_W-1:0]          term_ext;
  logic signed [ACC_W-1:0]          acc_add;
  logic signed [ACC_W-1:0]          lim_s;
  logic signed [ACC_W-1:0]          acc_clamped;

  function automatic logic [ltstdp_pkg::AGE_W-1:0] age_next(
    input logic [ltstdp_pkg::AGE_W-1:0] age,
    input logic                         spike
  );
    logic [ltstdp_pkg::AGE_W-1:0] res;
    if (spike) begin
      res = '0;
    end else if (age == ltstdp_pkg::AGE_MAX) begin
      res = ltstdp_pkg::AGE_MAX;
    end else begin
      res = age + 1'b1;
    end
    return res;
  endfunction

  always_comb begin
    sel_tau     = phase_ltd_r ? ltd_tau_r : ltp_tau_r;
    sel_idx     = phase_ltd_r ? post_age_r : pre_age_r;
    sel_amp     = phase_ltd_r ? AMP_BITS'(ltd_amp_r) : AMP_BITS'(ltp_amp_r);
    sel_tau_eff = (sel_tau > ltstdp_pkg::TAU_W'(MAX_TAU)) ? ltstdp_pkg::TAU_W'(MAX_TAU)
                                                         : sel_tau;
    sel_len     = (ltstdp_pkg::AGE_W+1)'({sel_tau_eff, 1'b0})
                + (ltstdp_pkg::AGE_W+1)'(sel_tau_eff);
    sel_zero    = (sel_tau_eff == '0) || ({1'b0, sel_idx} >= sel_len);
  end

  // divider kick: first step from setup, further steps while the age is not reached
  always_comb begin
    div_start_nxt = 1'b0;
    if (state_r == S_SETUP) begin
      div_start_nxt = !sel_zero && (sel_idx != '0);
    end else if (state_r == S_DIV) begin
      div_start_nxt = div_done && (ltstdp_pkg::AGE_W'(iter_r + 1'b1) != idx_r);
    end
  end

  // shifted term; depression rounds the magnitude up before negation
  always_comb begin
    sel_shift = phase_ltd_r ? ltd_shift_r : ltp_shift_r;
    term      = mag_r >> sel_shift;
    term_rnd  = |(mag_r & ~({AMP_BITS{1'b1}} << sel_shift));
    term_ext  = $signed(ACC_W'(term));
    if (phase_ltd_r) begin
      acc_add = acc_r - term_ext - $signed(ACC_W'(term_rnd));
    end else begin
      acc_add = acc_r + term_ext;
    end
  end

  always_comb begin
    lim_s = $signed(ACC_W'(limit_r));
    if (excit_r) begin
      acc_clamped = (acc_r >= lim_s) ? lim_s : acc_r;
      if (acc_clamped < 0) begin
        acc_clamped = '0;
      end
    end else begin
      acc_clamped = (acc_r < -lim_s) ? -lim_s : acc_r;
      if (acc_clamped > 0) begin
        acc_clamped = '0;
      end
    end
  end

  ltstdp_div #(
    .AMP_BITS (AMP_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (mag_r),
    .divisor  (tau_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ltp_amp_r   <= '0;
      ltd_amp_r   <= '0;
      ltp_tau_r   <= ltstdp_pkg::TAU_W'(1);
      ltd_tau_r   <= ltstdp_pkg::TAU_W'(1);
      ltp_shift_r <= '0;
      ltd_shift_r <= '0;
      limit_r     <= '0;
      excit_r     <= 1'b1;
      weight_r    <= '0;
      pre_age_r   <= ltstdp_pkg::AGE_MAX;
      post_age_r  <= ltstdp_pkg::AGE_MAX;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      phase_ltd_r <= 1'b0;
    end else begin
      div_start_r <= div_start_nxt;

      if (cfg_we) begin
        case (cfg_index)
          ltstdp_pkg::CFG_LTP_AMP:   ltp_amp_r   <= cfg_wdata;
          ltstdp_pkg::CFG_LTD_AMP:   ltd_amp_r   <= cfg_wdata;
          ltstdp_pkg::CFG_LTP_TAU:   ltp_tau_r   <= cfg_wdata[ltstdp_pkg::TAU_W-1:0];
          ltstdp_pkg::CFG_LTD_TAU:   ltd_tau_r   <= cfg_wdata[ltstdp_pkg::TAU_W-1:0];
          ltstdp_pkg::CFG_LTP_SHIFT: ltp_shift_r <= cfg_wdata[ltstdp_pkg::SHIFT_W-1:0];
          ltstdp_pkg::CFG_LTD_SHIFT: ltd_shift_r <= cfg_wdata[ltstdp_pkg::SHIFT_W-1:0];
          ltstdp_pkg::CFG_LIMIT:     limit_r     <= cfg_wdata[ltstdp_pkg::LIMIT_W-1:0];
          ltstdp_pkg::CFG_EXCIT:     excit_r     <= cfg_wdata[0];
          default: ;
        endcase
      end

      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.command == ltstdp_pkg::CMD_LOAD) begin
              weight_r <= in_data.load_value;
              upd_r    <= 1'b0;
              state_r  <= S_DONE;
            end else begin
              pre_age_r   <= age_next(pre_age_r, in_data.pre_spike);
              post_age_r  <= age_next(post_age_r, in_data.post_spike);
              pre_r       <= in_data.pre_spike;
              acc_r       <= ACC_W'(weight_r);
              // potentiation first when a post spike is present
              phase_ltd_r <= !in_data.post_spike;
              upd_r       <= 1'b0;
              if (in_data.pre_spike || in_data.post_spike) begin
                state_r <= S_SETUP;
              end else begin
                state_r <= S_DONE;
              end
            end
          end
        end
        S_SETUP: begin
          mag_r  <= sel_zero ? '0 : sel_amp;
          idx_r  <= sel_idx;
          tau_r  <= sel_tau_eff;
          iter_r <= '0;
          if (sel_zero || sel_idx == '0) begin
            state_r <= S_ADD;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          // one recurrence step: m <= m - m / tau
          if (div_done) begin
            mag_r  <= mag_r - div_quo;
            iter_r <= iter_r + 1'b1;
            if (ltstdp_pkg::AGE_W'(iter_r + 1'b1) == idx_r) begin
              state_r <= S_ADD;
            end
          end
        end
        S_ADD: begin
          acc_r <= acc_add;
          if (!phase_ltd_r && pre_r) begin
            phase_ltd_r <= 1'b1;
            state_r     <= S_SETUP;
          end else begin
            state_r <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          weight_r <= acc_clamped[ltstdp_pkg::WEIGHT_W-1:0];
          upd_r    <= 1'b1;
          state_r  <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r.weight_out <= weight_r;
            out_data_r.updated    <= upd_r;
            state_r               <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: bench/tb.sv
// testbench for the lookup-table stdp weight update block: predicts each weight beat and checks it
`timescale 1ns / 100ps

module tb;

  localparam int MAX_TAU       = 64;
  localparam int AMP_BITS      = 20;
  localparam int LONG_HOLD_AT  = 100;
  localparam int LONG_HOLD_LEN = 400;
  localparam int IDLE_PAD      = 10;

  logic                             clk;
  logic                             rst_n     = 1'b0;
  logic                             in_valid  = 1'b0;
  logic                             in_stall;
  ltstdp_pkg::in_beat_t             in_data   = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  ltstdp_pkg::out_beat_t            out_data;
  logic                             cfg_we    = 1'b0;
  logic [ltstdp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ltstdp_pkg::CFG_W-1:0]     cfg_wdata = '0;

  lookup_table_stdp_weight_update_top #(
    .MAX_TAU (MAX_TAU),
    .AMP_BITS(AMP_BITS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // register copy, reset values
  int unsigned ltp_amp   = 0;
  int unsigned ltd_amp   = 0;
  int unsigned ltp_tau   = 1;
  int unsigned ltd_tau   = 1;
  int unsigned ltp_shift = 0;
  int unsigned ltd_shift = 0;
  int unsigned w_limit   = 0;
  bit          excit     = 1'b1;

  // synapse state
  int          syn_weight = 0;
  int unsigned pre_age    = 255;
  int unsigned post_age   = 255;

  ltstdp_pkg::in_beat_t  tick_q[$];
  ltstdp_pkg::out_beat_t pending_weights[$];
  int        send_gap     = 0;
  bit        steady       = 1'b0;
  int        weights_seen = 0;
  int        mismatches   = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // table magnitude at idx, zero from 3*tau on
  function automatic longint decayed_mag(int unsigned amp, int unsigned tau, int unsigned idx);
    longint      m;
    int unsigned t;
    m = longint'(amp & ((1 << AMP_BITS) - 1));
    t = (tau > MAX_TAU) ? MAX_TAU : tau;
    if (t == 0 || idx >= 3 * t) return 0;
    for (int unsigned i = 0; i < idx; i++) m = m - m / longint'(t);
    return m;
  endfunction

  function automatic int unsigned aged(int unsigned age, bit spike);
    if (spike) return 0;
    return (age >= 255) ? 255 : age + 1;
  endfunction

  function automatic ltstdp_pkg::out_beat_t step_synapse(ltstdp_pkg::in_beat_t b);
    ltstdp_pkg::out_beat_t r;
    longint    w;
    longint    lim;
    longint    m;
    r.updated = 1'b0;
    if (b.command == ltstdp_pkg::CMD_LOAD) begin
      syn_weight = b.load_value;
    end else begin
      pre_age  = aged(pre_age, b.pre_spike);
      post_age = aged(post_age, b.post_spike);
      if (b.pre_spike || b.post_spike) begin
        w   = syn_weight;
        lim = w_limit;
        if (b.post_spike) w += decayed_mag(ltp_amp, ltp_tau, pre_age) >>> ltp_shift;
        if (b.pre_spike) begin
          m = decayed_mag(ltd_amp, ltd_tau, post_age);
          // shifting the negated entry rounds toward minus infinity
          w -= (m + ((longint'(1) << ltd_shift) - 1)) >>> ltd_shift;
        end
        if (excit) begin
          if (w >= lim) w = lim;
          if (w < 0) w = 0;
        end else begin
          if (w < -lim) w = -lim;
          if (w > 0) w = 0;
        end
        syn_weight = int'(w);
        r.updated  = 1'b1;
      end
    end
    r.weight_out = 16'(syn_weight);
    return r;
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) pending_weights = {pending_weights, step_synapse(in_data)};
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          in_data  <= tick_q.pop_front();
          in_valid <= 1'b1;
          if (!steady && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off so the block backs up
  int  stall_left     = 0;
  bit  long_hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!long_hold_done && weights_seen >= LONG_HOLD_AT) begin
      long_hold_done = 1'b1;
      stall_left     = LONG_HOLD_LEN - 1;
      out_stall     <= 1'b1;
    end else if (!steady && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    ltstdp_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      weights_seen <= weights_seen + 1;
      if (pending_weights.size() == 0) begin
        $error("unexpected beat: weight_out %0d updated %0b", out_data.weight_out,
               out_data.updated);
        mismatches++;
      end else begin
        want = pending_weights.pop_front();
        if (out_data.weight_out !== want.weight_out) begin
          $error("weight_out: expected %0d, actual %0d", want.weight_out, out_data.weight_out);
          mismatches++;
        end
        if (out_data.updated !== want.updated) begin
          $error("updated: expected %0b, actual %0b", want.updated, out_data.updated);
          mismatches++;
        end
      end
    end
  end

  task automatic push_tick(bit pre, bit post);
    ltstdp_pkg::in_beat_t b;
    b.command    = ltstdp_pkg::CMD_TICK;
    b.pre_spike  = pre;
    b.post_spike = post;
    b.load_value = 16'($urandom);
    tick_q = {tick_q, b};
  endtask

  task automatic push_load(int value);
    ltstdp_pkg::in_beat_t b;
    b.command    = ltstdp_pkg::CMD_LOAD;
    b.pre_spike  = 1'($urandom_range(0, 1));
    b.post_spike = 1'($urandom_range(0, 1));
    b.load_value = 16'(value);
    tick_q = {tick_q, b};
  endtask

  task automatic push_quiet(int n);
    repeat (n) push_tick(1'b0, 1'b0);
  endtask

  task automatic random_ticks(int n, int spike_pct, int load_pct);
    repeat (n) begin
      if ($urandom_range(0, 99) < load_pct)
        push_load($urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 32767 : -32768)
                                            : int'($signed(16'($urandom))));
      else
        push_tick($urandom_range(0, 99) < spike_pct, $urandom_range(0, 99) < spike_pct);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (tick_q.size() != 0 || in_valid || pending_weights.size() != 0);
    repeat (IDLE_PAD) @(posedge clk);
  endtask

  // writes every register, only while the block is idle
  task automatic configure(int unsigned p_amp, int unsigned d_amp, int unsigned p_tau,
                           int unsigned d_tau, int unsigned p_sh, int unsigned d_sh,
                           int unsigned lim, int unsigned ex);
    logic [ltstdp_pkg::CFG_IDX_W-1:0] regs[8];
    int unsigned                      vals[8];
    regs = '{ltstdp_pkg::CFG_LTP_AMP, ltstdp_pkg::CFG_LTD_AMP,
             ltstdp_pkg::CFG_LTP_TAU, ltstdp_pkg::CFG_LTD_TAU,
             ltstdp_pkg::CFG_LTP_SHIFT, ltstdp_pkg::CFG_LTD_SHIFT,
             ltstdp_pkg::CFG_LIMIT, ltstdp_pkg::CFG_EXCIT};
    vals = '{p_amp, d_amp, p_tau, d_tau, p_sh, d_sh, lim, ex};
    for (int k = 0; k < 8; k++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= regs[k];
      cfg_wdata <= ltstdp_pkg::CFG_W'(vals[k]);
    end
    @(posedge clk);
    cfg_we    <= 1'b0;
    ltp_amp   = p_amp & 32'hFFFFF;
    ltd_amp   = d_amp & 32'hFFFFF;
    ltp_tau   = p_tau & 32'h7F;
    ltd_tau   = d_tau & 32'h7F;
    ltp_shift = p_sh & 32'h1F;
    ltd_shift = d_sh & 32'h1F;
    w_limit   = lim & 32'h7FFF;
    excit     = ex[0];
    @(negedge clk);
  endtask

  task automatic random_phase(int n);
    configure($urandom_range(0, 32'hFFFFF), $urandom_range(0, 32'hFFFFF),
              $urandom_range(1, 16), $urandom_range(1, 16),
              $urandom_range(0, 12), $urandom_range(0, 12),
              $urandom_range(0, 32767), $urandom_range(0, 1));
    random_ticks(n, 30, 8);
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: short tables, ages at both ends, clamps and loads
    configure(1000, 800, 2, 2, 0, 0, 32767, 1);
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);  // pre age still saturated
    push_tick(1'b1, 1'b0);
    push_load(5000);
    push_tick(1'b1, 1'b1);  // both tables at index 0
    push_tick(1'b1, 1'b0);
    push_quiet(4);
    push_tick(1'b0, 1'b1);  // last table entry
    push_tick(1'b0, 1'b1);  // one past the table
    push_load(32767);
    push_tick(1'b1, 1'b1);
    push_load(-32768);
    push_tick(1'b0, 1'b0);  // weight left unclamped
    push_tick(1'b1, 1'b0);
    push_load(-1);
    push_tick(1'b0, 1'b1);
    wait_drained();

    // longest tables, sparse spikes, age running into saturation
    configure(32'hFFFFF, 32'hFFFFF, 64, 64, 5, 5, 32767, 1);
    push_tick(1'b1, 1'b0);
    push_quiet(190);
    push_tick(1'b0, 1'b1);
    push_quiet(70);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b0);
    random_ticks(200, 3, 4);
    wait_drained();

    // inhibitory clamp, with a pause until the block has drained
    configure(20000, 30000, 7, 3, 2, 0, 12000, 0);
    random_ticks(125, 25, 8);
    wait_drained();
    random_ticks(125, 25, 8);
    wait_drained();

    // empty potentiation table, over-range depression tau, zero limit
    configure(5000, 0, 0, 127, 0, 31, 0, 1);
    random_ticks(150, 20, 8);
    wait_drained();

    configure(0, 32'hFFFFF, 127, 0, 31, 3, 32767, 0);
    random_ticks(150, 10, 8);
    wait_drained();

    configure(32'hFFFFF, 1, 1, 1, 0, 31, 32767, 1);
    random_ticks(60, 40, 10);
    wait_drained();

    repeat (4) random_phase(50);

    @(posedge clk);
    steady <= 1'b1;
    random_phase(200);

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #300_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
